// ===== hw/rtl/istl_pkg.sv =====
// Shared types and constants for the interval start table lookup block.
// Holds the op and status codes, the result record and default sizes.
// No dependencies.
`default_nettype none

package istl_pkg;

  // Default table capacity
  localparam int unsigned MAX_REGIONS_DEF = 32;

  // Fixed field widths
  localparam int unsigned OFFSET_W    = 32;
  localparam int unsigned REGION_IDX_W = 5;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_ORDER     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_FETCH_CUR,
    S_FETCH_NXT,
    S_DONE
  } state_t;

  // One result record
  typedef struct packed {
    status_t                   status;
    logic [REGION_IDX_W-1:0]   region_index;
    logic [OFFSET_W-1:0]       region_start;
    logic                      has_next;
    logic [OFFSET_W-1:0]       next_start;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/istl_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module istl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/istl_ctrl.sv =====
// Sequencer for the start table: append, clear and binary-search query.
// Depends on istl_pkg and istl_ram (the start table storage).
`default_nettype none

module istl_ctrl #(
  parameter int unsigned MAX_REGIONS = istl_pkg::MAX_REGIONS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_op,
  input  wire logic [istl_pkg::OFFSET_W-1:0] in_offset,
  input  wire logic                          out_free,
  output logic                               res_valid,
  output istl_pkg::result_t                  res
);

  localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_REGIONS);

  istl_pkg::state_t             state, state_next;
  logic [CNT_W-1:0]             entry_count, entry_count_next;
  logic [istl_pkg::OFFSET_W-1:0] last_start, last_start_next;
  logic [istl_pkg::OFFSET_W-1:0] loc, loc_next;
  logic [CNT_W-1:0]             lo, lo_next;
  logic [CNT_W-1:0]             hi, hi_next;
  logic [CNT_W-1:0]             mid, mid_next;
  istl_pkg::result_t            res_next;

  logic [CNT_W-1:0]             mid_calc;
  logic [CNT_W-1:0]             lo_m1;
  logic                         full;

  logic                          mem_we;
  logic [IDX_W-1:0]              mem_waddr;
  logic [istl_pkg::OFFSET_W-1:0] mem_wdata;
  logic [IDX_W-1:0]              mem_raddr;
  logic [istl_pkg::OFFSET_W-1:0] mem_rdata;

  // Start table storage
  istl_ram #(
    .WIDTH (istl_pkg::OFFSET_W),
    .DEPTH (MAX_REGIONS)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign mid_calc = lo + ((hi - lo) >> 1);
  assign lo_m1    = lo - CNT_W'(1);
  assign full     = (entry_count >= CNT_W'(MAX_REGIONS));
  assign res_valid = (state == istl_pkg::S_DONE);

  // Next state and outputs
  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    last_start_next  = last_start;
    loc_next         = loc;
    lo_next          = lo;
    hi_next          = hi;
    mid_next         = mid;
    res_next         = res;
    in_ready         = 1'b0;
    mem_we           = 1'b0;
    mem_waddr        = entry_count[IDX_W-1:0];
    mem_wdata        = in_offset;
    mem_raddr        = mid_calc[IDX_W-1:0];

    case (state)
      istl_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          loc_next = in_offset;
          res_next = '0;
          case (istl_pkg::op_t'(in_op))
            istl_pkg::OP_APPEND: begin
              if (full) begin
                res_next.status = istl_pkg::ST_FULL;
              end else if ((entry_count != '0) && (in_offset < last_start)) begin
                res_next.status = istl_pkg::ST_ORDER;
              end else begin
                // Store the new start; the last start is kept for the order check
                mem_we                = 1'b1;
                entry_count_next      = entry_count + CNT_W'(1);
                last_start_next       = in_offset;
                res_next.status       = istl_pkg::ST_OK;
                res_next.region_index = istl_pkg::REGION_IDX_W'(entry_count);
                res_next.region_start = in_offset;
              end
              state_next = istl_pkg::S_DONE;
            end
            istl_pkg::OP_CLEAR: begin
              entry_count_next = '0;
              res_next.status  = istl_pkg::ST_OK;
              state_next       = istl_pkg::S_DONE;
            end
            istl_pkg::OP_QUERY: begin
              lo_next    = '0;
              hi_next    = entry_count;
              state_next = istl_pkg::S_SRCH_RD;
            end
            default: begin
              res_next.status = istl_pkg::ST_NOT_FOUND;
              state_next      = istl_pkg::S_DONE;
            end
          endcase
        end
      end

      // Issue a probe at the midpoint, or finish the search
      istl_pkg::S_SRCH_RD: begin
        if (lo < hi) begin
          mem_raddr  = mid_calc[IDX_W-1:0];
          mid_next   = mid_calc;
          state_next = istl_pkg::S_SRCH_CMP;
        end else if (lo == '0) begin
          res_next        = '0;
          res_next.status = istl_pkg::ST_NOT_FOUND;
          state_next      = istl_pkg::S_DONE;
        end else begin
          mem_raddr  = lo_m1[IDX_W-1:0];
          state_next = istl_pkg::S_FETCH_CUR;
        end
      end

      // Narrow the bounds toward the first start above the location
      istl_pkg::S_SRCH_CMP: begin
        if (mem_rdata <= loc) begin
          lo_next = mid + CNT_W'(1);
        end else begin
          hi_next = mid;
        end
        state_next = istl_pkg::S_SRCH_RD;
      end

      // Capture the found region, fetch the following one if present
      istl_pkg::S_FETCH_CUR: begin
        res_next.status       = istl_pkg::ST_OK;
        res_next.region_index = istl_pkg::REGION_IDX_W'(lo_m1);
        res_next.region_start = mem_rdata;
        res_next.has_next     = 1'b0;
        res_next.next_start   = '0;
        if (lo < entry_count) begin
          mem_raddr  = lo[IDX_W-1:0];
          state_next = istl_pkg::S_FETCH_NXT;
        end else begin
          state_next = istl_pkg::S_DONE;
        end
      end

      istl_pkg::S_FETCH_NXT: begin
        res_next.has_next   = 1'b1;
        res_next.next_start = mem_rdata;
        state_next          = istl_pkg::S_DONE;
      end

      // Hold the result until the output register is free
      istl_pkg::S_DONE: begin
        if (out_free) begin
          state_next = istl_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = istl_pkg::S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= istl_pkg::S_IDLE;
      entry_count <= '0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
    end
  end

  // Search and result registers
  always_ff @(posedge clk) begin
    last_start <= last_start_next;
    loc        <= loc_next;
    lo         <= lo_next;
    hi         <= hi_next;
    mid        <= mid_next;
    res        <= res_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_REGIONS))
    else $error("entry count above capacity");

  a_bounds_order: assert property (@(posedge clk) disable iff (rst)
    (state == istl_pkg::S_SRCH_RD || state == istl_pkg::S_SRCH_CMP) |->
      (lo <= hi && hi <= entry_count))
    else $error("search bounds crossed");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (!full && state == istl_pkg::S_IDLE))
    else $error("table write without room");

  a_fetch_found: assert property (@(posedge clk) disable iff (rst)
    (state == istl_pkg::S_FETCH_CUR) |-> (lo != '0 && lo <= entry_count))
    else $error("fetch of region outside the table");

endmodule

`default_nettype wire

// ===== hw/rtl/interval_start_table_lookup.sv =====
// Top level of the interval start table lookup: stream ports and output register.
// Depends on istl_pkg and istl_ctrl.
//
// Channel   Dir  tdata (low bit up)                          tuser
// s_axis    in   offset[31:0]                                op[1:0]
// m_axis    out  region_index[4:0], region_start[31:0],      status[1:0]
//                has_next, next_start[31:0], 2 zero bits
//
// Append, clear and an unused op go from acceptance straight to the done state;
// the next item is accepted after the result is loaded into the output register.
// A query runs S binary search steps, S at most ceil(log2(count+1)), 6 with 32
// entries, and when found then fetches the found region and the following region
// if there is one; each step is a table read plus a compare through the single
// read port of the start table.
// Reset (rst, synchronous) empties the table and drops any pending result; no
// clearing pass is needed. A stalled output holds its result while the next
// item is accepted and worked on; that item waits only at its own result.
`default_nettype none

module interval_start_table_lookup #(
  parameter int unsigned MAX_REGIONS = istl_pkg::MAX_REGIONS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // offset[31:0]
  input  wire logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // region_index[4:0], region_start[36:5],
                                           // has_next[37], next_start[69:38], zero
  output logic [1:0]       m_axis_tuser    // status[1:0]
);

  logic              out_free;
  logic              res_valid;
  istl_pkg::result_t res;
  istl_pkg::result_t out_res;

  istl_ctrl #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_offset (s_axis_tdata),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      out_res <= res;
    end
  end

  // Pack the result transaction
  assign m_axis_tuser = out_res.status;
  assign m_axis_tdata = {2'b00, out_res.next_start, out_res.has_next,
                         out_res.region_start, out_res.region_index};

endmodule

`default_nettype wire
